FILE: sv/cao_pkg.sv
// shared types, constants and helpers for the cursor alpha overlay unit
package cao_pkg;

  // coordinate and cursor limits
  localparam int COORD_MAX  = 4096;
  localparam int CURSOR_MAX = 256;
  localparam int COORD_W    = $clog2(COORD_MAX);
  localparam int LIM_W      = COORD_W + 1;
  localparam int LOCAL_W    = 8;
  localparam int HOT_W      = 8;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // configuration register map (index = paddr / 4)
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_X         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_Y         = 3'd5;

  // reset values
  localparam logic [LIM_W-1:0] SCREEN_WIDTH_RST  = LIM_W'(1920);
  localparam logic [LIM_W-1:0] SCREEN_HEIGHT_RST = LIM_W'(1080);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [LIM_W-1:0]   screen_width;
    logic [LIM_W-1:0]   screen_height;
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [HOT_W-1:0]   hot_x;
    logic [HOT_W-1:0]   hot_y;
  } cfg_t;

  // one classified request as it sits in the queue
  typedef struct packed {
    logic               wr_en;
    logic               opaque;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [31:0]        cur_px;
    logic [31:0]        bg_px;
  } item_t;

  // queue handshake signals seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // exact x / 255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

FILE: sv/cao_regs.sv
// apb configuration registers for the cursor overlay
module cao_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cao_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output cao_pkg::cfg_t                   cfg_o
);
  import cao_pkg::*;

  cfg_t                 cfg_q;
  logic                 wr;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= SCREEN_WIDTH_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
      cfg_q.cursor_x      <= '0;
      cfg_q.cursor_y      <= '0;
      cfg_q.hot_x         <= '0;
      cfg_q.hot_y         <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[LIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[LIM_W-1:0];
        REG_CURSOR_X:      cfg_q.cursor_x      <= pwdata[COORD_W-1:0];
        REG_CURSOR_Y:      cfg_q.cursor_y      <= pwdata[COORD_W-1:0];
        REG_HOT_X:         cfg_q.hot_x         <= pwdata[HOT_W-1:0];
        REG_HOT_Y:         cfg_q.hot_y         <= pwdata[HOT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SCREEN_WIDTH:  prdata = 32'(cfg_q.screen_width);
      REG_SCREEN_HEIGHT: prdata = 32'(cfg_q.screen_height);
      REG_CURSOR_X:      prdata = 32'(cfg_q.cursor_x);
      REG_CURSOR_Y:      prdata = 32'(cfg_q.cursor_y);
      REG_HOT_X:         prdata = 32'(cfg_q.hot_x);
      REG_HOT_Y:         prdata = 32'(cfg_q.hot_y);
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: sv/cao_front.sv
// front end: takes cursor pixel requests, places and classifies them
module cao_front (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cao_pkg::LOCAL_W-1:0]       local_x_i,
  input  logic [cao_pkg::LOCAL_W-1:0]       local_y_i,
  input  logic [31:0]                       cursor_pixel_i,
  input  logic [31:0]                       bg_pixel_i,
  input  cao_pkg::cfg_t                     cfg_i,
  input  cao_pkg::q_stat_t                  q_stat_i,
  output logic                              push_o,
  output cao_pkg::item_t                    item_o
);
  import cao_pkg::*;

  logic               on_x, on_y;
  logic [COORD_W-1:0] dx, dy;
  logic               wr_en;

  // destination = pos + local - hot, clipped to screen and coordinate range
  function automatic logic place(input logic [COORD_W-1:0] pos,
                                 input logic [LOCAL_W-1:0] loc,
                                 input logic [HOT_W-1:0]   hot,
                                 input logic [LIM_W-1:0]   lim,
                                 output logic [COORD_W-1:0] dst);
    logic [LIM_W-1:0] sum;
    logic [LIM_W-1:0] d;
    logic             neg;
    sum = LIM_W'(pos) + LIM_W'(loc);
    neg = sum < LIM_W'(hot);
    d   = sum - LIM_W'(hot);
    dst = d[COORD_W-1:0];
    return !neg && (d < lim) && (d < LIM_W'(COORD_MAX))
           && ((LIM_W + 1)'(loc) < (LIM_W + 1)'(CURSOR_MAX));
  endfunction

  always_comb begin
    on_x  = place(cfg_i.cursor_x, local_x_i, cfg_i.hot_x, cfg_i.screen_width, dx);
    on_y  = place(cfg_i.cursor_y, local_y_i, cfg_i.hot_y, cfg_i.screen_height, dy);
    wr_en = on_x && on_y && (cursor_pixel_i[31:24] != 8'd0);
  end

  // accept whenever the queue has room
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i & in_ready_o;

  // classified request
  always_comb begin
    item_o.wr_en  = wr_en;
    item_o.opaque = cursor_pixel_i[31:24] == ALPHA_OPAQUE;
    item_o.dest_x = wr_en ? dx : '0;
    item_o.dest_y = wr_en ? dy : '0;
    item_o.cur_px = cursor_pixel_i;
    item_o.bg_px  = bg_pixel_i;
  end

endmodule

FILE: sv/cao_queue.sv
// short request queue between front and back
module cao_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cao_pkg::item_t    item_i,
  input  logic              pop_i,
  output cao_pkg::item_t    item_o,
  output cao_pkg::q_stat_t  stat_o
);
  import cao_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign stat_o.full      = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign stat_o.not_empty = cnt_q != '0;
  assign item_o           = mem[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/cao_back.sv
// back end: two-stage blend pipeline with output register
module cao_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cao_pkg::q_stat_t             q_stat_i,
  input  cao_pkg::item_t               item_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         write_enable_o,
  output logic [cao_pkg::COORD_W-1:0]  dest_x_o,
  output logic [cao_pkg::COORD_W-1:0]  dest_y_o,
  output logic [7:0]                   out_blue_o,
  output logic [7:0]                   out_green_o,
  output logic [7:0]                   out_red_o,
  output logic [7:0]                   out_alpha_o
);
  import cao_pkg::*;

  // stage 1: products
  logic        s1_valid_q;
  item_t       s1_item_q;
  logic [15:0] s1_pb_q, s1_pg_q, s1_pr_q, s1_pa_q;
  logic        s1_en, s2_en;
  logic [7:0]  a, inv_a;

  // stage 2: output register
  logic               s2_valid_q;
  logic               s2_we_q;
  logic [COORD_W-1:0] s2_dx_q, s2_dy_q;
  logic [7:0]         s2_b_q, s2_g_q, s2_r_q, s2_a_q;

  assign s2_en = !s2_valid_q || out_ready_i;
  assign s1_en = !s1_valid_q || s2_en;
  assign pop_o = q_stat_i.not_empty && s1_en;

  assign a     = item_i.cur_px[31:24];
  assign inv_a = ALPHA_OPAQUE - a;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= q_stat_i.not_empty;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // weighted sums c*a + bg*(255-a) per colour channel, and bg alpha * (255-a) for alpha
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= item_i;
      s1_pb_q   <= 16'(item_i.cur_px[7:0])   * 16'(a) + 16'(item_i.bg_px[7:0])   * 16'(inv_a);
      s1_pg_q   <= 16'(item_i.cur_px[15:8])  * 16'(a) + 16'(item_i.bg_px[15:8])  * 16'(inv_a);
      s1_pr_q   <= 16'(item_i.cur_px[23:16]) * 16'(a) + 16'(item_i.bg_px[23:16]) * 16'(inv_a);
      s1_pa_q   <= 16'(item_i.bg_px[31:24]) * 16'(inv_a);
    end
  end

  // divide by 255 and pick the result form
  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_we_q <= s1_item_q.wr_en;
      s2_dx_q <= s1_item_q.dest_x;
      s2_dy_q <= s1_item_q.dest_y;
      if (!s1_item_q.wr_en) begin
        s2_b_q <= s1_item_q.bg_px[7:0];
        s2_g_q <= s1_item_q.bg_px[15:8];
        s2_r_q <= s1_item_q.bg_px[23:16];
        s2_a_q <= s1_item_q.bg_px[31:24];
      end else if (s1_item_q.opaque) begin
        s2_b_q <= s1_item_q.cur_px[7:0];
        s2_g_q <= s1_item_q.cur_px[15:8];
        s2_r_q <= s1_item_q.cur_px[23:16];
        s2_a_q <= s1_item_q.cur_px[31:24];
      end else begin
        s2_b_q <= div255(s1_pb_q);
        s2_g_q <= div255(s1_pg_q);
        s2_r_q <= div255(s1_pr_q);
        s2_a_q <= s1_item_q.cur_px[31:24] + div255(s1_pa_q);
      end
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign write_enable_o = s2_we_q;
  assign dest_x_o       = s2_dx_q;
  assign dest_y_o       = s2_dy_q;
  assign out_blue_o     = s2_b_q;
  assign out_green_o    = s2_g_q;
  assign out_red_o      = s2_r_q;
  assign out_alpha_o    = s2_a_q;

endmodule

FILE: sv/cursor_alpha_overlay_unit.sv
// top level of the cursor alpha overlay unit
//
//   channel   direction  handshake                  payload
//   in        request    in_valid_i / in_ready_o    local_x, local_y, cursor_pixel, bg_pixel
//   out       result     out_valid_o / out_ready_i  write_enable, dest_x/y, out_blue..alpha
//   cfg       apb write  psel, penable, pwrite      paddr, pwdata, prdata
//
// one request per clock sustained while out_ready_i holds; out_valid_o rises after the request passes
// the queue slot written at the accepting edge, then the product stage, then the divide/output stage
// reset empties the four-entry queue and both pipeline stages, registers take reset values
// a stalled output holds the pipeline; the queue keeps accepting until four requests wait
module cursor_alpha_overlay_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cao_pkg::LOCAL_W-1:0]     local_x_i,
  input  logic [cao_pkg::LOCAL_W-1:0]     local_y_i,
  input  logic [31:0]                     cursor_pixel_i,
  input  logic [31:0]                     bg_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            write_enable_o,
  output logic [cao_pkg::COORD_W-1:0]     dest_x_o,
  output logic [cao_pkg::COORD_W-1:0]     dest_y_o,
  output logic [7:0]                      out_blue_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_alpha_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cao_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import cao_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  item_t   push_item, head_item;
  logic    push, pop;

  cao_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cao_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .local_x_i      (local_x_i),
    .local_y_i      (local_y_i),
    .cursor_pixel_i (cursor_pixel_i),
    .bg_pixel_i     (bg_pixel_i),
    .cfg_i          (cfg),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .item_o         (push_item)
  );

  cao_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  cao_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .item_i         (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .dest_x_o       (dest_x_o),
    .dest_y_o       (dest_y_o),
    .out_blue_o     (out_blue_o),
    .out_green_o    (out_green_o),
    .out_red_o      (out_red_o),
    .out_alpha_o    (out_alpha_o)
  );

endmodule

FILE: sv/cao_checker.sv
// port-level checks for the cursor alpha overlay unit
module cao_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            write_enable_o,
  input logic [cao_pkg::COORD_W-1:0]     dest_x_o,
  input logic [cao_pkg::COORD_W-1:0]     dest_y_o,
  input logic [7:0]                      out_blue_o,
  input logic [7:0]                      out_alpha_o,
  input logic                            pready
);

  // a stalled result stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its write enable, x destination and blue channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(write_enable_o) && $stable(dest_x_o) && $stable(out_blue_o))
    else $error("result payload changed while stalled");

  // no write means a zero destination
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> dest_x_o == '0 && dest_y_o == '0)
    else $error("destination set without write");

  // a written pixel keeps at least the nonzero cursor alpha
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> out_alpha_o != 8'd0)
    else $error("written pixel has zero alpha");

  // the register port never inserts wait states
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind cursor_alpha_overlay_unit cao_checker u_cao_checker (.*);
